/* hdl/ranging_frame_deframer_assert.svh */
// Assertion macros used by the ranging frame deframer back end.
`ifndef RANGING_FRAME_DEFRAMER_ASSERT_SVH
`define RANGING_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTH
`define RFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rfd assertion failed");
`define RFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfd assertion failed");
`else
`define RFD_ASSERT(lbl, clk, rst_n, prop)
`define RFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rfd_pkg.sv */
// Types and constants of the ranging frame deframer.
package rfd_pkg;
    localparam int ANCHOR_COUNT = 8;
    localparam int FRAME_BYTES  = 37;
    localparam int STORE_DEPTH  = 64;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int FILL_W       = 6;
    localparam int AIDX_W       = 3;
    localparam int OFS_VERSION  = 2;
    localparam int OFS_DATA     = 3;
    localparam int OFS_CHECKSUM = FRAME_BYTES - 2;
    localparam int OFS_FOOTER   = FRAME_BYTES - 1;
    localparam int DATA_END     = OFS_DATA + 4 * ANCHOR_COUNT;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_FOOTER = 2'd2;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_GOOD = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_HEADER   = 3'd2,
        ERR_FOOTER   = 3'd3,
        ERR_CHECKSUM = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_hdr;
        logic       is_len;
    } t_qitem;
endpackage

/* hdl/rfd_chan_if.sv */
// Channel interfaces for received bytes and result records.
interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, rx_byte, input ready);
    modport sink (input valid, rx_byte, output ready);
endinterface

interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic [7:0]  version;
    logic [2:0]  anchor_index;
    logic [31:0] anchor_dist;
    logic        anchor_valid;
    logic [7:0]  anchor_mask;
    logic        last;
    logic [31:0] accepted_count;
    logic [31:0] rejected_count;
    modport source (output valid, status, error_code, version, anchor_index, anchor_dist,
                    anchor_valid, anchor_mask, last, accepted_count, rejected_count,
                    input ready);
    modport sink (input valid, status, error_code, version, anchor_index, anchor_dist,
                  anchor_valid, anchor_mask, last, accepted_count, rejected_count,
                  output ready);
endinterface

/* hdl/rfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/rfd_front.sv */
// Front end: accepts bytes, tags header and length matches, queues them.
module rfd_front
    import rfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfd_in_if.sink     i_rx,
    input  logic [7:0] i_header,
    input  logic [7:0] i_length,
    output t_qitem     o_item,
    output logic       o_item_valid,
    input  logic       i_item_pop
);
    t_qitem     r_q [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_qitem     item;

    assign i_rx.ready   = (r_cnt != 2'(QUEUE_DEPTH));
    assign push         = i_rx.valid && i_rx.ready;
    assign item.rx_byte = i_rx.rx_byte;
    assign item.is_hdr  = (i_rx.rx_byte == i_header);
    assign item.is_len  = (i_rx.rx_byte == i_length);
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_item_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_item_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

/* hdl/rfd_back.sv */
// Back end: frame store, frame checks, resync search and result records.
`include "ranging_frame_deframer_assert.svh"
module rfd_back
    import rfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qitem     i_item,
    input  logic       i_item_valid,
    output logic       o_item_pop,
    input  logic [7:0] i_header,
    input  logic [7:0] i_length,
    input  logic [7:0] i_footer,
    rfd_out_if.source  o_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_JUDGE, S_DECIDE, S_EREAD, S_EOUT
    } t_state;

    t_state                r_state;
    logic [FILL_W-1:0]     r_fill;
    logic [STORE_AW-1:0]   r_base;
    logic [31:0]           r_good;
    logic [31:0]           r_bad;
    logic [5:0]            r_iss;
    logic [7:0]            r_sum;
    logic                  r_hdr_ok;
    logic                  r_len_ok;
    logic                  r_chk_ok;
    logic                  r_foot_ok;
    logic                  r_last_hdr;
    logic                  r_found;
    logic [FILL_W-1:0]     r_pos;
    logic [7:0]            r_prev;
    logic                  r_z;
    logic                  r_o;
    logic [ANCHOR_COUNT-1:0] r_mask;
    logic [7:0]            r_version;
    logic [AIDX_W-1:0]     r_anchor;
    logic [2:0]            r_k;
    logic [31:0]           r_dist;

    logic                  r_ov;
    t_status               r_o_status;
    t_err                  r_o_err;
    logic [7:0]            r_o_version;
    logic [AIDX_W-1:0]     r_o_anchor;
    logic [31:0]           r_o_dist;
    logic                  r_o_aval;
    logic [ANCHOR_COUNT-1:0] r_o_mask;
    logic                  r_o_last;
    logic [31:0]           r_o_good;
    logic [31:0]           r_o_bad;

    logic                  out_free;
    logic                  we;
    logic [STORE_AW-1:0]   waddr;
    logic [STORE_AW-1:0]   raddr;
    logic [7:0]            rd;
    logic [5:0]            p;
    logic [5:0]            off;
    logic                  in_data;
    logic                  z_new;
    logic                  o_new;
    logic                  pair_hit;
    t_err                  err;
    logic                  last_issue;
    logic                  good_beat;

    rfd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.rx_byte),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    assign out_free = !r_ov || o_res.ready;
    assign p        = r_iss - 6'd1;
    assign off      = p - 6'(OFS_DATA);
    assign in_data  = (p >= 6'(OFS_DATA)) && (p < 6'(DATA_END));
    assign z_new    = ((off[1:0] == 2'd0) || r_z) && (rd == 8'h00);
    assign o_new    = ((off[1:0] == 2'd0) || r_o) && (rd == 8'hFF);
    assign pair_hit = (p >= 6'd2) && !r_found && (r_prev == i_header) && (rd == i_length);
    assign last_issue = (r_state == S_EOUT) && out_free
                        && (r_anchor == AIDX_W'(ANCHOR_COUNT - 1));
    assign good_beat  = r_ov && (r_o_status == ST_GOOD);

    always_comb begin
        if (!r_hdr_ok) begin
            err = ERR_HEADER;
        end else if (!r_len_ok) begin
            err = ERR_LENGTH;
        end else if (!r_foot_ok) begin
            err = ERR_FOOTER;
        end else if (!r_chk_ok) begin
            err = ERR_CHECKSUM;
        end else begin
            err = ERR_NONE;
        end
    end

    always_comb begin
        o_item_pop = 1'b0;
        we         = 1'b0;
        waddr      = r_base;
        raddr      = r_base;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && out_free) begin
                    o_item_pop = 1'b1;
                    if (r_fill == '0 || (r_fill == FILL_W'(1) && !i_item.is_len)) begin
                        we = i_item.is_hdr;
                    end else begin
                        we    = 1'b1;
                        waddr = r_base + STORE_AW'(r_fill);
                    end
                end
            end
            S_JUDGE: begin
                raddr = r_base + STORE_AW'(r_iss);
            end
            S_EREAD: begin
                raddr = r_base + STORE_AW'(OFS_DATA) + STORE_AW'({r_anchor, 2'b00})
                        + STORE_AW'(r_k[1:0]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_base  <= '0;
            r_good  <= '0;
            r_bad   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_item_pop) begin
                        r_o_status  <= ST_NONE;
                        r_o_err     <= ERR_NONE;
                        r_o_version <= '0;
                        r_o_anchor  <= '0;
                        r_o_dist    <= '0;
                        r_o_aval    <= 1'b0;
                        r_o_mask    <= '0;
                        r_o_last    <= 1'b1;
                        r_o_good    <= r_good;
                        r_o_bad     <= r_bad;
                        if (r_fill == '0) begin
                            r_ov <= 1'b1;
                            if (i_item.is_hdr) begin
                                r_fill <= FILL_W'(1);
                            end
                        end else if (r_fill == FILL_W'(1) && !i_item.is_len) begin
                            r_ov       <= 1'b1;
                            r_bad      <= r_bad + 32'd1;
                            r_o_bad    <= r_bad + 32'd1;
                            r_o_status <= ST_BAD;
                            r_o_err    <= ERR_LENGTH;
                            r_fill     <= i_item.is_hdr ? FILL_W'(1) : '0;
                        end else begin
                            r_fill <= r_fill + FILL_W'(1);
                            if (r_fill + FILL_W'(1) == FILL_W'(FRAME_BYTES)) begin
                                r_state <= S_JUDGE;
                                r_iss   <= '0;
                                r_sum   <= '0;
                                r_found <= 1'b0;
                                r_mask  <= '0;
                            end else begin
                                r_ov <= 1'b1;
                            end
                        end
                    end
                end
                S_JUDGE: begin
                    r_iss <= r_iss + 6'd1;
                    if (r_iss != '0) begin
                        r_prev <= rd;
                        if (p == 6'd0) begin
                            r_hdr_ok <= (rd == i_header);
                        end
                        if (p == 6'd1) begin
                            r_len_ok <= (rd == i_length);
                        end
                        if (p == 6'(OFS_VERSION)) begin
                            r_version <= rd;
                        end
                        if (p < 6'(OFS_CHECKSUM)) begin
                            r_sum <= r_sum + rd;
                        end
                        if (p == 6'(OFS_CHECKSUM)) begin
                            r_chk_ok <= (rd == r_sum);
                        end
                        if (p == 6'(OFS_FOOTER)) begin
                            r_foot_ok  <= (rd == i_footer);
                            r_last_hdr <= (rd == i_header);
                        end
                        if (in_data) begin
                            r_z <= z_new;
                            r_o <= o_new;
                            if (off[1:0] == 2'd3) begin
                                r_mask[off[AIDX_W+1:2]] <= !(z_new || o_new);
                            end
                        end
                        if (pair_hit) begin
                            r_found <= 1'b1;
                            r_pos   <= FILL_W'(p - 6'd1);
                        end
                        if (r_iss == 6'(FRAME_BYTES)) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        if (err == ERR_NONE) begin
                            r_good   <= r_good + 32'd1;
                            r_fill   <= '0;
                            r_anchor <= '0;
                            r_k      <= '0;
                            r_state  <= S_EREAD;
                        end else begin
                            r_bad       <= r_bad + 32'd1;
                            r_ov        <= 1'b1;
                            r_o_status  <= ST_BAD;
                            r_o_err     <= err;
                            r_o_version <= '0;
                            r_o_anchor  <= '0;
                            r_o_dist    <= '0;
                            r_o_aval    <= 1'b0;
                            r_o_mask    <= '0;
                            r_o_last    <= 1'b1;
                            r_o_good    <= r_good;
                            r_o_bad     <= r_bad + 32'd1;
                            if (r_found) begin
                                r_base <= r_base + STORE_AW'(r_pos);
                                r_fill <= FILL_W'(FRAME_BYTES) - r_pos;
                            end else if (r_last_hdr) begin
                                r_base <= r_base + STORE_AW'(OFS_FOOTER);
                                r_fill <= FILL_W'(1);
                            end else begin
                                r_fill <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EREAD: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) begin
                        r_dist <= {rd, r_dist[31:8]};
                    end
                    if (r_k == 3'd4) begin
                        r_state <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_o_status  <= ST_GOOD;
                        r_o_err     <= ERR_NONE;
                        r_o_version <= r_version;
                        r_o_anchor  <= r_anchor;
                        r_o_dist    <= r_dist;
                        r_o_aval    <= r_mask[r_anchor];
                        r_o_mask    <= r_mask;
                        r_o_last    <= (r_anchor == AIDX_W'(ANCHOR_COUNT - 1));
                        r_o_good    <= r_good;
                        r_o_bad     <= r_bad;
                        r_k         <= '0;
                        if (r_anchor == AIDX_W'(ANCHOR_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_anchor <= r_anchor + AIDX_W'(1);
                            r_state  <= S_EREAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.status         = r_o_status;
    assign o_res.error_code     = r_o_err;
    assign o_res.version        = r_o_version;
    assign o_res.anchor_index   = r_o_anchor;
    assign o_res.anchor_dist    = r_o_dist;
    assign o_res.anchor_valid   = r_o_aval;
    assign o_res.anchor_mask    = r_o_mask;
    assign o_res.last           = r_o_last;
    assign o_res.accepted_count = r_o_good;
    assign o_res.rejected_count = r_o_bad;

    `RFD_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill <= FILL_W'(FRAME_BYTES))
    `RFD_ASSERT(a_good_no_err, i_clk, i_rst_n, !(good_beat && r_o_err != ERR_NONE))
    `RFD_ASSERT_NEXT(a_last_rec, i_clk, i_rst_n, last_issue, r_state == S_IDLE && r_o_last)
endmodule

/* hdl/ranging_frame_deframer.sv */
// Ranging frame deframer top level: register port, front end and back end.
//
// Bytes from the serial link arrive on i_rx, one per beat; result records
// leave on o_res, one per beat. Every byte gives one record, except the byte
// that completes a good frame, which gives one record per anchor, the final
// one marked by last. Software loads the header, length and footer values
// through the register port while the block is idle.
// A byte that does not complete a frame passes the two-entry input queue and
// the back-end output register before its record is valid on o_res. The
// completing byte starts a scan of the stored frame, one byte a cycle through
// the single read port of the frame store, to check the frame and find the
// next header-plus-length pair; each anchor record is then read from the
// store byte by byte.
// Reset empties the queue and the frame store and clears both counters and
// the registers. When the receiver stalls, the result stays in the output
// register, the back end stops and the input queue fills, after which i_rx
// ready drops until the back end moves on.
module ranging_frame_deframer
    import rfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfd_in_if.sink      i_rx,
    rfd_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0] r_header;
    logic [7:0] r_length;
    logic [7:0] r_footer;
    t_qitem     item;
    logic       item_valid;
    logic       item_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
            r_length <= '0;
            r_footer <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_HEADER: r_header <= pwdata[7:0];
                REG_LENGTH: r_length <= pwdata[7:0];
                REG_FOOTER: r_footer <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HEADER: prdata = {24'd0, r_header};
            REG_LENGTH: prdata = {24'd0, r_length};
            REG_FOOTER: prdata = {24'd0, r_footer};
            default:    prdata = '0;
        endcase
    end

    rfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_header     (r_header),
        .i_length     (r_length),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    rfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_header     (r_header),
        .i_length     (r_length),
        .i_footer     (r_footer),
        .o_res        (o_res)
    );
endmodule

/* tb/ranging_frame_deframer_tb.sv */
// Self-checking testbench for the ranging frame deframer: byte stimulus, predicted records.
`timescale 1ns / 1ps

module ranging_frame_deframer_tb
    import rfd_pkg::*;
();
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  error_code;
        logic [7:0]  version;
        logic [2:0]  anchor_index;
        logic [31:0] anchor_dist;
        logic        anchor_valid;
        logic [7:0]  anchor_mask;
        logic        last;
        logic [31:0] accepted_count;
        logic [31:0] rejected_count;
    } t_record;

    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rfd_in_if  rx_if ();
    rfd_out_if res_if ();

    ranging_frame_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]  hdr_val;
    logic [7:0]  len_val;
    logic [7:0]  ftr_val;
    logic [7:0]  frame_buf [FRAME_BYTES];
    int          fill;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    t_record     expected_records [$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_res = 1'b0;

    initial begin
        rx_if.valid = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_res) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !(idle_on && $urandom_range(99) < 29);
        end
    end

    always @(posedge i_clk) begin
        t_record got;
        t_record want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.status, res_if.error_code, res_if.version, res_if.anchor_index,
                    res_if.anchor_dist, res_if.anchor_valid, res_if.anchor_mask, res_if.last,
                    res_if.accepted_count, res_if.rejected_count};
            if (expected_records.size() == 0) begin
                $error("record with none expected");
                errors++;
            end else begin
                want = expected_records.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.error_code !== want.error_code) begin
                    $error("error_code exp %0d got %0d", want.error_code, got.error_code);
                    errors++;
                end
                if (got.version !== want.version) begin
                    $error("version exp %0h got %0h", want.version, got.version); errors++;
                end
                if (got.anchor_index !== want.anchor_index) begin
                    $error("anchor_index exp %0d got %0d", want.anchor_index, got.anchor_index);
                    errors++;
                end
                if (got.anchor_dist !== want.anchor_dist) begin
                    $error("anchor_dist exp %0h got %0h", want.anchor_dist, got.anchor_dist);
                    errors++;
                end
                if (got.anchor_valid !== want.anchor_valid) begin
                    $error("anchor_valid exp %0d got %0d", want.anchor_valid, got.anchor_valid);
                    errors++;
                end
                if (got.anchor_mask !== want.anchor_mask) begin
                    $error("anchor_mask exp %0h got %0h", want.anchor_mask, got.anchor_mask);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); errors++;
                end
                if (got.accepted_count !== want.accepted_count) begin
                    $error("accepted_count exp %0d got %0d", want.accepted_count,
                           got.accepted_count);
                    errors++;
                end
                if (got.rejected_count !== want.rejected_count) begin
                    $error("rejected_count exp %0d got %0d", want.rejected_count,
                           got.rejected_count);
                    errors++;
                end
            end
        end
    end

    function automatic t_record plain_record(logic [1:0] st, logic [2:0] err);
        t_record r;
        r = '0;
        r.status = st;
        r.error_code = err;
        r.last = 1'b1;
        r.accepted_count = good_cnt;
        r.rejected_count = bad_cnt;
        return r;
    endfunction

    function automatic logic [2:0] frame_fault();
        logic [7:0] sum;
        sum = '0;
        if (frame_buf[0] != hdr_val) return ERR_HEADER;
        if (frame_buf[1] != len_val) return ERR_LENGTH;
        if (frame_buf[OFS_FOOTER] != ftr_val) return ERR_FOOTER;
        for (int i = 0; i < OFS_CHECKSUM; i++) sum += frame_buf[i];
        if (frame_buf[OFS_CHECKSUM] != sum) return ERR_CHECKSUM;
        return ERR_NONE;
    endfunction

    function automatic logic [31:0] anchor_distance(int a);
        int base;
        base = OFS_DATA + 4 * a;
        return {frame_buf[base + 3], frame_buf[base + 2], frame_buf[base + 1], frame_buf[base]};
    endfunction

    function automatic void resync_store();
        for (int i = 1; i + 1 < fill; i++) begin
            if (frame_buf[i] == hdr_val && frame_buf[i + 1] == len_val) begin
                for (int j = 0; j < fill - i; j++) frame_buf[j] = frame_buf[i + j];
                fill = fill - i;
                return;
            end
        end
        if (fill > 0 && frame_buf[fill - 1] == hdr_val) begin
            frame_buf[0] = hdr_val;
            fill = 1;
        end else begin
            fill = 0;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        logic [2:0] err;
        logic [7:0] mask;
        t_record r;
        if (fill == 0) begin
            if (b == hdr_val) begin
                frame_buf[0] = b;
                fill = 1;
            end
            expected_records.push_back(plain_record(ST_NONE, ERR_NONE));
            return;
        end
        if (fill == 1 && b != len_val) begin
            bad_cnt++;
            fill = 0;
            if (b == hdr_val) begin
                frame_buf[0] = b;
                fill = 1;
            end
            expected_records.push_back(plain_record(ST_BAD, ERR_LENGTH));
            return;
        end
        frame_buf[fill] = b;
        fill++;
        if (fill < FRAME_BYTES) begin
            expected_records.push_back(plain_record(ST_NONE, ERR_NONE));
            return;
        end
        err = frame_fault();
        if (err != ERR_NONE) begin
            bad_cnt++;
            resync_store();
            expected_records.push_back(plain_record(ST_BAD, err));
            return;
        end
        fill = 0;
        good_cnt++;
        mask = '0;
        for (int a = 0; a < ANCHOR_COUNT; a++)
            if (anchor_distance(a) != 0 && anchor_distance(a) != 32'hFFFF_FFFF) mask[a] = 1'b1;
        for (int a = 0; a < ANCHOR_COUNT; a++) begin
            r = plain_record(ST_GOOD, ERR_NONE);
            r.version = frame_buf[OFS_VERSION];
            r.anchor_index = 3'(a);
            r.anchor_dist = anchor_distance(a);
            r.anchor_valid = mask[a];
            r.anchor_mask = mask;
            r.last = (a == ANCHOR_COUNT - 1);
            expected_records.push_back(r);
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        while (idle_on && $urandom_range(99) < 29) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        predict_byte(b);
        do @(posedge i_clk); while (!rx_if.ready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HEADER: hdr_val = val;
            REG_LENGTH: len_val = val;
            default:    ftr_val = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_framing(logic [7:0] h, logic [7:0] l, logic [7:0] f);
        drain();
        write_reg(REG_HEADER, h);
        write_reg(REG_LENGTH, l);
        write_reg(REG_FOOTER, f);
    endtask

    // Mode 0 good, 1 bad checksum, 2 bad footer, 3 special distances.
    task automatic send_frame(int mode);
        logic [7:0] fr [FRAME_BYTES];
        logic [7:0] sum;
        int pick;
        fr[0] = hdr_val;
        fr[1] = len_val;
        fr[OFS_VERSION] = 8'($urandom);
        for (int i = OFS_DATA; i < OFS_CHECKSUM; i++) fr[i] = 8'($urandom);
        if (mode == 3) begin
            for (int a = 0; a < ANCHOR_COUNT; a++) begin
                pick = $urandom_range(2);
                for (int k = 0; k < 4; k++)
                    if (pick == 0) fr[OFS_DATA + 4 * a + k] = 8'h00;
                    else if (pick == 1) fr[OFS_DATA + 4 * a + k] = 8'hFF;
            end
        end
        sum = '0;
        for (int i = 0; i < OFS_CHECKSUM; i++) sum += fr[i];
        fr[OFS_CHECKSUM] = (mode == 1) ? sum + 8'd1 : sum;
        fr[OFS_FOOTER] = (mode == 2) ? ftr_val + 8'd1 : ftr_val;
        foreach (fr[i]) send_byte(fr[i]);
    endtask

    task automatic test_directed();
        set_framing(8'hAA, 8'h25, 8'h55);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h13);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_frame(1);
        send_frame(2);
    endtask

    task automatic test_extremes();
        set_framing(8'h00, 8'hFF, 8'hFF);
        send_frame(0);
    endtask

    task automatic test_random();
        set_framing(8'($urandom), 8'($urandom), 8'($urandom));
        send_frame(int'($urandom_range(3)));
        repeat ($urandom_range(1, 8))
            send_byte($urandom_range(1) ? hdr_val : 8'($urandom));
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        send_frame(3);
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_res = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_res = 1'b0;
            end
            begin
                send_frame(0);
            end
        join
    endtask

    initial begin
        hdr_val = '0;
        len_val = '0;
        ftr_val = '0;
        fill = 0;
        good_cnt = '0;
        bad_cnt = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extremes();
        test_random();
        test_no_idle();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/rfd_pkg.sv
hdl/rfd_chan_if.sv
hdl/rfd_ram.sv
hdl/rfd_front.sv
hdl/rfd_back.sv
hdl/ranging_frame_deframer.sv
tb/ranging_frame_deframer_tb.sv
